/* hw/rtl/hqr_pkg.sv */
// Shared types and constants of the Householder QR block.
`default_nettype none
package hqr_pkg;

  localparam int MAX_ROWS_DEF    = 8;
  localparam int MAX_COLUMNS_DEF = 4;
  localparam int ROW_RESET       = 8;
  localparam int COL_RESET       = 4;
  localparam int ROW_REG_W       = 4;
  localparam int COL_REG_W       = 3;
  localparam int CFG_W           = 4;
  localparam int VALUE_W         = 32;
  localparam int ROW_IDX_W       = 3;
  localparam int COL_IDX_W       = 2;
  localparam int QUEUE_DEPTH     = 4;
  localparam int DIV_NUM_W       = 50;
  localparam int DIV_DEN_W       = 34;

  localparam logic [31:0] FX_ONE  = 32'h0001_0000;
  localparam logic [31:0] FX_TWO  = 32'h0002_0000;
  localparam logic [31:0] FX_ZERO = 32'h0000_0000;

  localparam logic CFG_ROW_COUNT    = 1'b0;
  localparam logic CFG_COLUMN_COUNT = 1'b1;

  typedef struct packed {
    logic [ROW_REG_W-1:0] row_count;
    logic [COL_REG_W-1:0] column_count;
  } cfg_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_COL,
    S_SS_RD,
    S_SS_MUL,
    S_SS_ACC,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_V_RD,
    S_V_GO,
    S_V_WAIT,
    S_TAU_GO,
    S_TAU_WAIT,
    S_DOT_COL,
    S_DOT_RD,
    S_DOT_MUL,
    S_DOT_ACC,
    S_DOT_SCALE,
    S_DOT_D,
    S_UPD_RD,
    S_UPD_MUL,
    S_UPD_WR,
    S_TAIL_WR,
    S_OUT_RD,
    S_OUT_EMIT,
    S_OUT_TAU
  } state_e;

endpackage
`default_nettype wire

/* hw/rtl/hqr_front.sv */
// Front end: configuration registers, element indexing and queue push.
`default_nettype none
module hqr_front import hqr_pkg::*; #(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  localparam int RIW = $clog2(MAX_ROWS),
  localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int QW  = VALUE_W + RIW + CIW + 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [VALUE_W-1:0] element_value_i,
  output logic                    busy_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_addr_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i,
  input  wire logic               q_full_i,
  output logic                    q_push_o,
  output logic [QW-1:0]           q_data_o,
  output cfg_t                    cfg_o
);

  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLUMNS + 1);
  localparam int RowInit = (ROW_RESET > MAX_ROWS) ? MAX_ROWS : ROW_RESET;
  localparam int ColInit = (COL_RESET > MAX_COLUMNS) ? MAX_COLUMNS : COL_RESET;

  logic [ROW_REG_W-1:0] row_count_q, row_count_d;
  logic [COL_REG_W-1:0] column_count_q, column_count_d;
  logic [RIW-1:0]       row_q, row_d;
  logic [CIW-1:0]       col_q, col_d;
  logic                 last_row, last_col;
  logic [ROW_REG_W-1:0] rv;
  logic [COL_REG_W-1:0] cv;

  assign busy_o   = q_full_i;
  assign q_push_o = start_i && !q_full_i;
  assign last_row = (RCW'(row_q) + RCW'(1)) == RCW'(row_count_q);
  assign last_col = (CCW'(col_q) + CCW'(1)) == CCW'(column_count_q);
  assign q_data_o = {element_value_i, row_q, col_q, last_row && last_col};
  assign cfg_o.row_count    = row_count_q;
  assign cfg_o.column_count = column_count_q;

  always_comb begin
    row_count_d    = row_count_q;
    column_count_d = column_count_q;
    row_d          = row_q;
    col_d          = col_q;
    rv             = cfg_wdata_i;
    cv             = cfg_wdata_i[COL_REG_W-1:0];
    if (rv == '0) rv = ROW_REG_W'(1);
    if (int'(rv) > MAX_ROWS) rv = ROW_REG_W'(MAX_ROWS);
    if (cv == '0) cv = COL_REG_W'(1);
    if (int'(cv) > MAX_COLUMNS) cv = COL_REG_W'(MAX_COLUMNS);
    if (cfg_we_i) begin
      row_d = '0;
      col_d = '0;
      case (cfg_addr_i)
        CFG_ROW_COUNT:    row_count_d    = rv;
        CFG_COLUMN_COUNT: column_count_d = cv;
        default:          row_count_d    = row_count_q;
      endcase
    end else if (q_push_o) begin
      if (last_row) begin
        row_d = '0;
        col_d = last_col ? '0 : col_q + CIW'(1);
      end else begin
        row_d = row_q + RIW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= ROW_REG_W'(RowInit);
      column_count_q <= COL_REG_W'(ColInit);
      row_q          <= '0;
      col_q          <= '0;
    end else begin
      row_count_q    <= row_count_d;
      column_count_q <= column_count_d;
      row_q          <= row_d;
      col_q          <= col_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/hqr_queue.sv */
// Short item queue between the front end and the compute engine.
`default_nettype none
module hqr_queue import hqr_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == NW'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    if (do_pop)  rptr_d = (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + NW'(1);
    if (do_pop && !do_push) cnt_d = cnt_q - NW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/hqr_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module hqr_divider import hqr_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DIV_NUM_W-1:0] dividend_i,
  input  wire logic [DIV_DEN_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [DIV_NUM_W-1:0]      quotient_o
);

  localparam int CW = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic [DIV_DEN_W:0]   shifted;
  logic                 fits;

  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = quo_q;
  assign shifted    = {rem_q, quo_q[DIV_NUM_W-1]};
  assign fits       = shifted >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
      cnt_d  = CW'(DIV_NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        rem_d = fits ? DIV_DEN_W'(shifted - {1'b0, den_q}) : shifted[DIV_DEN_W-1:0];
        quo_d = {quo_q[DIV_NUM_W-2:0], fits};
        cnt_d = cnt_q - CW'(1);
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/hqr_sqrt.sv */
// Rounded square root of a 64-bit value, two radicand bits per cycle.
`default_nettype none
module hqr_sqrt import hqr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] radicand_i,
  output logic             done_o,
  output logic [32:0]      root_o
);

  logic [63:0] s_q, s_d, res_q, res_d, bit_q, bit_d;
  logic        busy_q, busy_d;
  logic [64:0] trial;

  assign trial  = {1'b0, res_q} + {1'b0, bit_q};
  assign done_o = busy_q && (bit_q == '0);
  assign root_o = 33'(res_q) + 33'(s_q > res_q);

  always_comb begin
    s_d    = s_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    if (start_i) begin
      s_d    = radicand_i;
      res_d  = '0;
      bit_d  = 64'h4000_0000_0000_0000;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (bit_q != '0) begin
        if ({1'b0, s_q} >= trial) begin
          s_d   = s_q - trial[63:0];
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= 1'b0;
    else busy_q <= busy_d;
  end

endmodule
`default_nettype wire

/* hw/rtl/hqr_engine.sv */
// Back end: matrix store, reflector sequencer and result streaming.
`default_nettype none
module hqr_engine import hqr_pkg::*; #(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  localparam int RIW = $clog2(MAX_ROWS),
  localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int QW  = VALUE_W + RIW + CIW + 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfg_t                 cfg_i,
  input  wire logic                 q_valid_i,
  input  wire logic [QW-1:0]        q_data_i,
  output logic                      q_pop_o,
  output logic                      result_valid_o,
  output logic signed [VALUE_W-1:0] result_value_o,
  output logic                      is_tau_o,
  output logic [ROW_IDX_W-1:0]      row_index_o,
  output logic [COL_IDX_W-1:0]      column_index_o,
  output logic                      last_result_o
);

  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLUMNS + 1);
  localparam int XW  = (RCW > CCW) ? RCW : CCW;
  localparam int AD  = MAX_ROWS * MAX_COLUMNS;
  localparam int AW  = $clog2(AD);
  localparam int ACW = 33 + $clog2(MAX_ROWS);
  localparam logic signed [ACW-1:0] AccMax = ACW'(32'sh7fff_ffff);
  localparam logic signed [ACW-1:0] AccMin = ACW'(32'sh8000_0000);

  function automatic logic [31:0] sat_mag(input logic [63:0] mag, input logic neg);
    logic [31:0] r;
    if (neg) r = (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
    else r = (mag > 64'h7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [RCW-1:0] r, input logic [CCW-1:0] c);
    return AW'(c) * AW'(MAX_ROWS) + AW'(r);
  endfunction

  logic [31:0] mem_q [AD];

  state_e state_q, state_d;
  logic [CCW-1:0]        i_q, i_d, j_q, j_d;
  logic [RCW-1:0]        k_q, k_d;
  logic signed [31:0]    rd_q;
  logic signed [63:0]    prod_q;
  logic [63:0]           ss_q, ss_d, asq_q, asq_d;
  logic signed [31:0]    alpha_q, alpha_d;
  logic [32:0]           r_q, r_d;
  logic signed [34:0]    v0_q, v0_d;
  logic                  neg_q, neg_d;
  logic [31:0]           v_q [MAX_ROWS];
  logic [31:0]           v_d [MAX_ROWS];
  logic [31:0]           tau_q [MAX_COLUMNS];
  logic [31:0]           tau_d [MAX_COLUMNS];
  logic [31:0]           tau_cur_q, tau_cur_d, d_q, d_d;
  logic signed [ACW-1:0] acc_q, acc_d;
  logic                  rv_q, rv_d, rt_q, rt_d, rl_q, rl_d;
  logic [31:0]           rval_q, rval_d;
  logic [ROW_IDX_W-1:0]  rrow_q, rrow_d;
  logic [COL_IDX_W-1:0]  rcol_q, rcol_d;

  logic [RCW-1:0]        m_w, len, row_ik, m1, k_next;
  logic [CCW-1:0]        n_w, nref;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         waddr, raddr;
  logic [31:0]           wdata;
  logic signed [31:0]    op_a, op_b;
  logic [63:0]           pmag, rnd;
  logic [31:0]           mq, acc_sat, vk, upd;
  logic [32:0]           upd_t;
  logic [64:0]           ss_sum, rad_sum;
  logic [33:0]           v0mag;
  logic [31:0]           xmag;
  logic                  div_start, div_done, sq_start, sq_done;
  logic [DIV_NUM_W-1:0]  div_num, div_quo;
  logic [DIV_DEN_W-1:0]  div_den;
  logic [32:0]           sq_root;
  logic [34:0]           a35, r35;
  logic [31:0]           qsat;
  logic [VALUE_W-1:0]    ent_value;
  logic [RIW-1:0]        ent_row;
  logic [CIW-1:0]        ent_col;
  logic                  ent_last;

  hqr_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  hqr_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (rad_sum[64] ? 64'hffff_ffff_ffff_ffff : rad_sum[63:0]),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  assign ent_value = q_data_i[QW-1 -: VALUE_W];
  assign ent_row   = q_data_i[RIW+CIW:CIW+1];
  assign ent_col   = q_data_i[CIW:1];
  assign ent_last  = q_data_i[0];

  assign m_w    = RCW'(cfg_i.row_count);
  assign n_w    = CCW'(cfg_i.column_count);
  assign m1     = m_w - RCW'(1);
  assign nref   = (XW'(n_w) < XW'(m1)) ? n_w : CCW'(m1);
  assign len    = m_w - RCW'(i_q);
  assign row_ik = RCW'(i_q) + k_q;
  assign k_next = k_q + RCW'(1);
  assign vk     = v_q[k_q[RIW-1:0]];

  assign pmag  = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
  assign rnd   = (pmag + 64'd32768) >> 16;
  assign mq    = sat_mag(rnd, prod_q[63]);
  assign acc_sat = (acc_q > AccMax) ? 32'h7fff_ffff :
                   (acc_q < AccMin) ? 32'h8000_0000 : acc_q[31:0];
  assign upd_t = {rd_q[31], rd_q} - {mq[31], mq};
  assign upd   = (upd_t[32] != upd_t[31]) ? (upd_t[32] ? 32'h8000_0000 : 32'h7fff_ffff)
                                          : upd_t[31:0];
  assign ss_sum  = {1'b0, ss_q} + {1'b0, prod_q};
  assign rad_sum = {1'b0, asq_q} + {1'b0, ss_q};
  assign v0mag   = v0_q[34] ? 34'(-v0_q) : v0_q[33:0];
  assign xmag    = rd_q[31] ? 32'(-rd_q) : rd_q;
  assign a35     = {{3{alpha_q[31]}}, alpha_q};
  assign r35     = {2'b00, sq_root};
  assign qsat    = sat_mag(64'(div_quo), neg_q);

  assign q_pop_o = (state_q == S_LOAD) && q_valid_i;

  assign result_valid_o = rv_q;
  assign result_value_o = rval_q;
  assign is_tau_o       = rt_q;
  assign row_index_o    = rrow_q;
  assign column_index_o = rcol_q;
  assign last_result_o  = rl_q;

  always_comb begin
    case (state_q)
      S_SS_MUL:    begin op_a = rd_q;    op_b = rd_q;      end
      S_DOT_MUL:   begin op_a = vk;      op_b = rd_q;      end
      S_DOT_SCALE: begin op_a = acc_sat; op_b = tau_cur_q; end
      S_UPD_MUL:   begin op_a = d_q;     op_b = vk;        end
      default:     begin op_a = rd_q;    op_b = vk;        end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    ss_d      = ss_q;
    asq_d     = asq_q;
    alpha_d   = alpha_q;
    r_d       = r_q;
    v0_d      = v0_q;
    neg_d     = neg_q;
    v_d       = v_q;
    tau_d     = tau_q;
    tau_cur_d = tau_cur_q;
    d_d       = d_q;
    acc_d     = acc_q;
    rv_d      = 1'b0;
    rt_d      = rt_q;
    rl_d      = rl_q;
    rval_d    = rval_q;
    rrow_d    = rrow_q;
    rcol_d    = rcol_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    waddr     = addr_of(row_ik, j_q);
    raddr     = addr_of(row_ik, j_q);
    wdata     = upd;
    div_start = 1'b0;
    div_num   = {16'b0, xmag, 2'b0};
    div_den   = v0mag;
    sq_start  = 1'b0;

    case (state_q)
      S_LOAD: begin
        if (q_valid_i) begin
          mem_we = 1'b1;
          waddr  = addr_of(RCW'(ent_row), CCW'(ent_col));
          wdata  = ent_value;
          if (ent_last) begin
            i_d     = '0;
            state_d = S_COL;
          end
        end
      end
      S_COL: begin
        if (i_q == nref) begin
          k_d     = '0;
          j_d     = '0;
          state_d = S_OUT_RD;
        end else begin
          v_d[0]  = FX_ONE;
          k_d     = '0;
          ss_d    = '0;
          state_d = S_SS_RD;
        end
      end
      S_SS_RD: begin
        mem_re  = 1'b1;
        raddr   = addr_of(row_ik, i_q);
        state_d = S_SS_MUL;
      end
      S_SS_MUL: state_d = S_SS_ACC;
      S_SS_ACC: begin
        if (k_q == '0) begin
          alpha_d = rd_q;
          asq_d   = prod_q;
        end else begin
          ss_d = ss_sum[64] ? 64'hffff_ffff_ffff_ffff : ss_sum[63:0];
        end
        k_d     = k_next;
        state_d = (k_next == len) ? S_ROOT_GO : S_SS_RD;
      end
      S_ROOT_GO: begin
        if (ss_q == '0) begin
          for (int x = 1; x < MAX_ROWS; x++) v_d[x] = FX_ZERO;
          tau_cur_d = alpha_q[31] ? FX_TWO : FX_ZERO;
          tau_d[i_q[CIW-1:0]] = alpha_q[31] ? FX_TWO : FX_ZERO;
          j_d     = i_q;
          k_d     = RCW'(1);
          state_d = alpha_q[31] ? S_DOT_COL : S_TAIL_WR;
        end else begin
          sq_start = 1'b1;
          state_d  = S_ROOT_WAIT;
        end
      end
      S_ROOT_WAIT: begin
        if (sq_done) begin
          r_d     = sq_root;
          v0_d    = alpha_q[31] ? 35'(a35 - r35) : 35'(a35 + r35);
          k_d     = RCW'(1);
          state_d = S_V_RD;
        end
      end
      S_V_RD: begin
        mem_re  = 1'b1;
        raddr   = addr_of(row_ik, i_q);
        state_d = S_V_GO;
      end
      S_V_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'({xmag, 16'b0}) + DIV_NUM_W'(v0mag >> 1);
        div_den   = v0mag;
        neg_d     = rd_q[31] ^ v0_q[34];
        state_d   = S_V_WAIT;
      end
      S_V_WAIT: begin
        if (div_done) begin
          v_d[k_q[RIW-1:0]] = qsat;
          k_d     = k_next;
          state_d = (k_next == len) ? S_TAU_GO : S_V_RD;
        end
      end
      S_TAU_GO: begin
        div_start = 1'b1;
        div_num   = {v0mag, 16'b0} + DIV_NUM_W'(r_q >> 1);
        div_den   = DIV_DEN_W'(r_q);
        neg_d     = 1'b0;
        state_d   = S_TAU_WAIT;
      end
      S_TAU_WAIT: begin
        if (div_done) begin
          tau_cur_d = qsat;
          tau_d[i_q[CIW-1:0]] = qsat;
          j_d     = i_q;
          k_d     = RCW'(1);
          state_d = (qsat == FX_ZERO) ? S_TAIL_WR : S_DOT_COL;
        end
      end
      S_DOT_COL: begin
        k_d     = '0;
        acc_d   = '0;
        state_d = S_DOT_RD;
      end
      S_DOT_RD: begin
        mem_re  = 1'b1;
        state_d = S_DOT_MUL;
      end
      S_DOT_MUL: state_d = S_DOT_ACC;
      S_DOT_ACC: begin
        acc_d   = acc_q + ACW'($signed(mq));
        k_d     = k_next;
        state_d = (k_next == len) ? S_DOT_SCALE : S_DOT_RD;
      end
      S_DOT_SCALE: state_d = S_DOT_D;
      S_DOT_D: begin
        d_d = mq;
        k_d = '0;
        if (mq != FX_ZERO) begin
          state_d = S_UPD_RD;
        end else if (j_q + CCW'(1) == n_w) begin
          k_d     = RCW'(1);
          state_d = S_TAIL_WR;
        end else begin
          j_d     = j_q + CCW'(1);
          state_d = S_DOT_COL;
        end
      end
      S_UPD_RD: begin
        mem_re  = 1'b1;
        state_d = S_UPD_MUL;
      end
      S_UPD_MUL: state_d = S_UPD_WR;
      S_UPD_WR: begin
        mem_we = 1'b1;
        wdata  = upd;
        k_d    = k_next;
        if (k_next != len) begin
          state_d = S_UPD_RD;
        end else if (j_q + CCW'(1) == n_w) begin
          k_d     = RCW'(1);
          state_d = S_TAIL_WR;
        end else begin
          j_d     = j_q + CCW'(1);
          state_d = S_DOT_COL;
        end
      end
      S_TAIL_WR: begin
        mem_we = 1'b1;
        waddr  = addr_of(row_ik, i_q);
        wdata  = vk;
        k_d    = k_next;
        if (k_next == len) begin
          i_d     = i_q + CCW'(1);
          state_d = S_COL;
        end
      end
      S_OUT_RD: begin
        mem_re  = 1'b1;
        raddr   = addr_of(k_q, j_q);
        state_d = S_OUT_EMIT;
      end
      S_OUT_EMIT: begin
        rv_d   = 1'b1;
        rt_d   = 1'b0;
        rval_d = rd_q;
        rrow_d = ROW_IDX_W'(k_q);
        rcol_d = COL_IDX_W'(j_q);
        rl_d   = 1'b0;
        state_d = S_OUT_RD;
        if (k_next == m_w) begin
          k_d = '0;
          if (j_q + CCW'(1) == n_w) begin
            i_d = '0;
            if (nref == '0) begin
              rl_d    = 1'b1;
              state_d = S_LOAD;
            end else begin
              state_d = S_OUT_TAU;
            end
          end else begin
            j_d = j_q + CCW'(1);
          end
        end else begin
          k_d = k_next;
        end
      end
      S_OUT_TAU: begin
        rv_d   = 1'b1;
        rt_d   = 1'b1;
        rval_d = tau_q[i_q[CIW-1:0]];
        rrow_d = '0;
        rcol_d = COL_IDX_W'(i_q);
        rl_d   = (i_q + CCW'(1)) == nref;
        i_d    = i_q + CCW'(1);
        if ((i_q + CCW'(1)) == nref) begin
          i_d     = '0;
          state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= wdata;
    if (mem_re) rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= op_a * op_b;
    ss_q      <= ss_d;
    asq_q     <= asq_d;
    alpha_q   <= alpha_d;
    r_q       <= r_d;
    v0_q      <= v0_d;
    neg_q     <= neg_d;
    v_q       <= v_d;
    tau_q     <= tau_d;
    tau_cur_q <= tau_cur_d;
    d_q       <= d_d;
    acc_q     <= acc_d;
    rt_q      <= rt_d;
    rl_q      <= rl_d;
    rval_q    <= rval_d;
    rrow_q    <= rrow_d;
    rcol_q    <= rcol_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      rv_q    <= rv_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/householder_qr_decomposition.sv */
// Householder QR decomposition, top level.
// Elements enter one per cycle through a four-item queue, column-major, with busy_o high only
// while the queue is full. The item that completes the matrix starts the decomposition; for
// each reflected column the engine forms the squared norm, takes the square root and runs the
// shared divider for each tail element and for tau, then, unless tau is zero, applies the
// reflector to that column and every later one. Results then stream out, the matrix elements
// first and the tau values after them; each is shown for a single cycle by result_valid_o and
// cannot be held off by the receiver. Items of the next matrix may be accepted while a run is
// still computing or streaming.
`default_nettype none
module householder_qr_decomposition import hqr_pkg::*; #(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic signed [VALUE_W-1:0] element_value_i,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_addr_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                      result_valid_o,
  output logic signed [VALUE_W-1:0] result_value_o,
  output logic                      is_tau_o,
  output logic [ROW_IDX_W-1:0]      row_index_o,
  output logic [COL_IDX_W-1:0]      column_index_o,
  output logic                      last_result_o
);

  localparam int RIW = $clog2(MAX_ROWS);
  localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int QW  = VALUE_W + RIW + CIW + 1;

  cfg_t          cfg;
  logic          q_full, q_push, q_pop, q_valid;
  logic [QW-1:0] q_in, q_out;

  hqr_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .element_value_i (element_value_i),
    .busy_o          (busy_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (q_in),
    .cfg_o           (cfg)
  );

  hqr_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  hqr_engine #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_valid_i      (q_valid),
    .q_data_i       (q_out),
    .q_pop_o        (q_pop),
    .result_valid_o (result_valid_o),
    .result_value_o (result_value_o),
    .is_tau_o       (is_tau_o),
    .row_index_o    (row_index_o),
    .column_index_o (column_index_o),
    .last_result_o  (last_result_o)
  );

endmodule
`default_nettype wire
